[hw/rtl/assert_macros.svh]
// Assertion macros used by the checker module.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define CHK_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Implication whose consequent is checked in the next cycle.
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

[hw/rtl/cts_pkg.sv]
// Package for the token scanner: token kinds, scan modes and shared types.
// Depends on nothing; imported by every scanner module.
package cts_pkg;

  typedef enum logic [4:0] {
    TK_EOF    = 5'd0,
    TK_IDENT  = 5'd1,
    TK_KW_INT = 5'd2,
    TK_INTLIT = 5'd9,
    TK_FLTLIT = 5'd10,
    TK_PLUS   = 5'd11,
    TK_MINUS  = 5'd12,
    TK_STAR   = 5'd13,
    TK_SLASH  = 5'd14,
    TK_ASSIGN = 5'd15,
    TK_EQ     = 5'd16,
    TK_NE     = 5'd17,
    TK_LT     = 5'd18,
    TK_LE     = 5'd19,
    TK_GT     = 5'd20,
    TK_GE     = 5'd21,
    TK_LPAREN = 5'd22,
    TK_RPAREN = 5'd23,
    TK_LBRACE = 5'd24,
    TK_RBRACE = 5'd25,
    TK_SEMI   = 5'd26,
    TK_COMMA  = 5'd27,
    TK_BAD    = 5'd28
  } tok_kind_t;

  typedef enum logic [3:0] {
    M_IDLE, M_IDENT, M_INT, M_INT_DOT, M_FRAC, M_OP_EQ, M_OP_BANG, M_OP_LT, M_OP_GT
  } scan_mode_t;

  localparam int NUM_KW = 7;
  localparam int KW_MAX = 6;

  // Keyword characters by keyword and position; zero past the end.
  function automatic logic [7:0] kw_char(input int k, input int p);
    logic [7:0] r;
    r = 8'h00;
    case (k)
      0: case (p) 0: r = "i"; 1: r = "n"; 2: r = "t"; default: r = 8'h00; endcase
      1: case (p) 0: r = "f"; 1: r = "l"; 2: r = "o"; 3: r = "a"; 4: r = "t";
           default: r = 8'h00; endcase
      2: case (p) 0: r = "b"; 1: r = "o"; 2: r = "o"; 3: r = "l"; default: r = 8'h00; endcase
      3: case (p) 0: r = "r"; 1: r = "e"; 2: r = "t"; 3: r = "u"; 4: r = "r"; 5: r = "n";
           default: r = 8'h00; endcase
      4: case (p) 0: r = "i"; 1: r = "f"; default: r = 8'h00; endcase
      5: case (p) 0: r = "e"; 1: r = "l"; 2: r = "s"; 3: r = "e"; default: r = 8'h00; endcase
      6: case (p) 0: r = "w"; 1: r = "h"; 2: r = "i"; 3: r = "l"; 4: r = "e";
           default: r = 8'h00; endcase
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] kw_len(input int k);
    logic [2:0] r;
    case (k)
      0: r = 3'd3; 1: r = 3'd5; 2: r = 3'd4; 3: r = 3'd6;
      4: r = 3'd2; 5: r = 3'd4; 6: r = 3'd5;
      default: r = 3'd0;
    endcase
    return r;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {["0":"9"]};
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c inside {["a":"z"]}) || (c inside {["A":"Z"]});
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == " ") || (c inside {[8'd9:8'd13]});
  endfunction

  function automatic tok_kind_t single_kind(input logic [7:0] c);
    tok_kind_t r;
    case (c)
      "+": r = TK_PLUS;
      "-": r = TK_MINUS;
      "*": r = TK_STAR;
      "/": r = TK_SLASH;
      "(": r = TK_LPAREN;
      ")": r = TK_RPAREN;
      "{": r = TK_LBRACE;
      "}": r = TK_RBRACE;
      ";": r = TK_SEMI;
      ",": r = TK_COMMA;
      default: r = TK_BAD;
    endcase
    return r;
  endfunction

endpackage

[hw/rtl/cts_front.sv]
// Front end of the token scanner: takes bytes, tracks the cursor and forms tokens.
// Depends on cts_pkg. Each accepted input produces up to three tokens in the cycle it is accepted.
module cts_front
  import cts_pkg::*;
#(
  parameter int OW = 32,
  parameter int LW = 16,
  parameter int CW = 16,
  parameter int NW = 16,
  parameter int TW = 5 + OW + LW + CW + NW + 8 + 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [7:0]        in_byte,
  input  logic              in_end,
  output logic [1:0]        tok_cnt,
  output logic [3*TW-1:0]   tok_data
);

  scan_mode_t     mode_r, mode_nxt;
  logic [OW-1:0]  off_r, off_nxt, soff_r, soff_nxt;
  logic [LW-1:0]  line_r, line_nxt, sline_r, sline_nxt;
  logic [CW-1:0]  col_r, col_nxt, scol_r, scol_nxt;
  logic [NW-1:0]  len_r, len_nxt;
  logic [NUM_KW-1:0] kw_r, kw_nxt;

  // Step the cursor over one byte, saturating each counter.
  function automatic void adv(input logic [7:0] c, inout logic [OW-1:0] o,
                              inout logic [LW-1:0] l, inout logic [CW-1:0] cl);
    if (o != '1) o = o + 1'b1;
    if (c == 8'h0a) begin
      if (l != '1) l = l + 1'b1;
      cl = CW'(1);
    end else if (cl != '1) begin
      cl = cl + 1'b1;
    end
  endfunction

  // Dispatch and emission logic for one input.
  always_comb begin
    logic [TW-1:0] t [3];
    logic [1:0] n;
    logic fl, idl;
    tok_kind_t ik;
    logic [7:0] c;
    for (int i = 0; i < 3; i++) t[i] = '0;
    n = 2'd0;
    fl = 1'b0;
    idl = 1'b0;
    ik = TK_IDENT;
    c = in_byte;
    mode_nxt = mode_r;
    off_nxt = off_r; line_nxt = line_r; col_nxt = col_r;
    soff_nxt = soff_r; sline_nxt = sline_r; scol_nxt = scol_r;
    len_nxt = len_r; kw_nxt = kw_r;
    for (int k = NUM_KW - 1; k >= 0; k--) begin
      if (kw_r[k] && len_r == NW'(kw_len(k))) begin
        ik = tok_kind_t'(5'(2 + k));
      end
    end
    if (in_valid) begin
      if (in_end) begin
        fl = 1'b1;
      end else begin
        case (mode_r)
          M_IDENT: if (is_alpha(c) || is_digit(c) || c == "_") begin
            for (int k = 0; k < NUM_KW; k++)
              if (len_r >= NW'(kw_len(k)) || kw_char(k, int'(len_r[2:0])) != c)
                kw_nxt[k] = 1'b0;
            if (len_nxt != '1) len_nxt = len_r + 1'b1;
            adv(c, off_nxt, line_nxt, col_nxt);
          end else begin fl = 1'b1; idl = 1'b1; end
          M_INT: if (is_digit(c)) begin
            if (len_nxt != '1) len_nxt = len_r + 1'b1;
            adv(c, off_nxt, line_nxt, col_nxt);
          end else if (c == ".") begin
            mode_nxt = M_INT_DOT;
          end else begin fl = 1'b1; idl = 1'b1; end
          M_INT_DOT: if (is_digit(c)) begin
            if (len_nxt != '1) len_nxt = len_nxt + 1'b1;
            if (len_nxt != '1) len_nxt = len_nxt + 1'b1;
            adv(".", off_nxt, line_nxt, col_nxt);
            adv(c, off_nxt, line_nxt, col_nxt);
            mode_nxt = M_FRAC;
          end else begin fl = 1'b1; idl = 1'b1; end
          M_FRAC: if (is_digit(c)) begin
            if (len_nxt != '1) len_nxt = len_r + 1'b1;
            adv(c, off_nxt, line_nxt, col_nxt);
          end else begin fl = 1'b1; idl = 1'b1; end
          M_OP_EQ, M_OP_BANG, M_OP_LT, M_OP_GT: if (c == "=") begin
            if (len_nxt != '1) len_nxt = len_r + 1'b1;
            adv(c, off_nxt, line_nxt, col_nxt);
            t[0] = {(mode_r == M_OP_EQ) ? TK_EQ : (mode_r == M_OP_BANG) ? TK_NE :
                    (mode_r == M_OP_LT) ? TK_LE : TK_GE,
                    soff_r, sline_r, scol_r, len_nxt, 8'h00, 1'b0};
            n = 2'd1;
            mode_nxt = M_IDLE;
          end else begin fl = 1'b1; idl = 1'b1; end
          default: idl = 1'b1;
        endcase
      end
      // Flush the held token.
      if (fl) begin
        case (mode_r)
          M_IDENT: begin
            t[n] = {ik, soff_r, sline_r, scol_r, len_r, 8'h00, 1'b0}; n = n + 1'b1;
          end
          M_INT: begin
            t[n] = {TK_INTLIT, soff_r, sline_r, scol_r, len_r, 8'h00, 1'b0}; n = n + 1'b1;
          end
          M_INT_DOT: begin
            t[n] = {TK_INTLIT, soff_r, sline_r, scol_r, len_r, 8'h00, 1'b0}; n = n + 1'b1;
            t[n] = {TK_BAD, off_nxt, line_nxt, col_nxt, NW'(1), 8'h2e, 1'b0};
            n = n + 1'b1;
            adv(".", off_nxt, line_nxt, col_nxt);
          end
          M_FRAC: begin
            t[n] = {TK_FLTLIT, soff_r, sline_r, scol_r, len_r, 8'h00, 1'b0}; n = n + 1'b1;
          end
          M_OP_EQ: begin
            t[n] = {TK_ASSIGN, soff_r, sline_r, scol_r, len_r, 8'h00, 1'b0}; n = n + 1'b1;
          end
          M_OP_BANG: begin
            t[n] = {TK_BAD, soff_r, sline_r, scol_r, NW'(1), 8'h21, 1'b0}; n = n + 1'b1;
          end
          M_OP_LT: begin
            t[n] = {TK_LT, soff_r, sline_r, scol_r, len_r, 8'h00, 1'b0}; n = n + 1'b1;
          end
          M_OP_GT: begin
            t[n] = {TK_GT, soff_r, sline_r, scol_r, len_r, 8'h00, 1'b0}; n = n + 1'b1;
          end
          default: ;
        endcase
        mode_nxt = M_IDLE;
      end
      if (in_end) begin
        t[n] = {TK_EOF, off_nxt, line_nxt, col_nxt, NW'(0), 8'h00, 1'b0};
        n = n + 1'b1;
      end
      // Start of a new token, or skip of a blank, in idle mode or after the held token ends.
      if (idl) begin
        mode_nxt = M_IDLE;
        if (is_space(c)) begin
          adv(c, off_nxt, line_nxt, col_nxt);
        end else begin
          soff_nxt = off_nxt; sline_nxt = line_nxt; scol_nxt = col_nxt;
          len_nxt = NW'(1);
          if (is_alpha(c) || c == "_") begin
            for (int k = 0; k < NUM_KW; k++) kw_nxt[k] = (kw_char(k, 0) == c);
            mode_nxt = M_IDENT;
          end else if (is_digit(c)) begin
            mode_nxt = M_INT;
          end else if (c == "=") begin
            mode_nxt = M_OP_EQ;
          end else if (c == "!") begin
            mode_nxt = M_OP_BANG;
          end else if (c == "<") begin
            mode_nxt = M_OP_LT;
          end else if (c == ">") begin
            mode_nxt = M_OP_GT;
          end else begin
            t[n] = {single_kind(c), off_nxt, line_nxt, col_nxt, NW'(1),
                    (single_kind(c) == TK_BAD) ? c : 8'h00, 1'b0};
            n = n + 1'b1;
          end
          adv(c, off_nxt, line_nxt, col_nxt);
        end
      end
      if (n != 2'd0) t[n - 1'b1][0] = 1'b1;
    end
    tok_cnt = n;
    tok_data = {t[2], t[1], t[0]};
  end

  // Scanner state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE;
      off_r <= '0; line_r <= LW'(1); col_r <= CW'(1);
      soff_r <= '0; sline_r <= LW'(1); scol_r <= CW'(1);
      len_r <= '0; kw_r <= '1;
    end else begin
      mode_r <= mode_nxt;
      off_r <= off_nxt; line_r <= line_nxt; col_r <= col_nxt;
      soff_r <= soff_nxt; sline_r <= sline_nxt; scol_r <= scol_nxt;
      len_r <= len_nxt; kw_r <= kw_nxt;
    end
  end

endmodule

[hw/rtl/cts_queue.sv]
// Token queue between the scanner front end and the result port.
// Depends on cts_pkg; takes up to three tokens per cycle, gives one per cycle.
module cts_queue
  import cts_pkg::*;
#(
  parameter int TW = 94,
  parameter int DEPTH = 8
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic [1:0]      wr_cnt,
  input  logic [3*TW-1:0] wr_data,
  input  logic            rd_en,
  output logic [TW-1:0]   rd_data,
  output logic            empty,
  output logic            room3
);

  localparam int AW = $clog2(DEPTH);
  logic [TW-1:0] mem_r [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;

  assign empty   = (cnt_r == '0);
  assign room3   = (cnt_r <= (AW + 1)'(DEPTH - 3));
  assign rd_data = mem_r[rp_r];

  // Slot writes: each of the three lanes lands at a fixed offset from the write pointer.
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++)
      if (2'(i) < wr_cnt) mem_r[wp_r + AW'(i)] <= wr_data[i*TW +: TW];
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      wp_r <= wp_r + AW'(wr_cnt);
      rp_r <= rp_r + AW'(rd_en);
      cnt_r <= cnt_r + (AW + 1)'(wr_cnt) - (AW + 1)'(rd_en);
    end
  end

endmodule

[hw/rtl/c_like_token_scanner_unit.sv]
// Token scanner top level: bytes in through the front end, token queue out.
// A token is written into the token queue when the byte that ends it is accepted.
// Throughput: one byte per cycle while full is low; full rises only while the eight-entry token queue
// has fewer than three free slots, as the front end may emit three tokens per byte.
// Reset: synchronous active-low rst_n clears the cursor to offset 0, line 1, column 1.
module c_like_token_scanner_unit
  import cts_pkg::*;
#(
  parameter int OFFSET_WIDTH = 32,
  parameter int LINE_WIDTH   = 16,
  parameter int COLUMN_WIDTH = 16,
  parameter int LENGTH_WIDTH = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  output logic                    full,
  input  logic [7:0]              in_source_byte,
  input  logic                    in_end_of_source,
  output logic                    empty,
  input  logic                    pop,
  output logic [4:0]              out_token_kind,
  output logic [OFFSET_WIDTH-1:0] out_start_offset,
  output logic [LINE_WIDTH-1:0]   out_start_line,
  output logic [COLUMN_WIDTH-1:0] out_start_column,
  output logic [LENGTH_WIDTH-1:0] out_token_length,
  output logic [7:0]              out_offending_byte,
  output logic                    out_last_of_run
);

  localparam int TW = 5 + OFFSET_WIDTH + LINE_WIDTH + COLUMN_WIDTH + LENGTH_WIDTH + 8 + 1;

  logic [1:0]      tok_cnt;
  logic [3*TW-1:0] tok_data;
  logic [TW-1:0]   rd_data;
  logic            room3;

  assign full = !room3;

  cts_front #(.OW(OFFSET_WIDTH), .LW(LINE_WIDTH), .CW(COLUMN_WIDTH),
              .NW(LENGTH_WIDTH), .TW(TW)) u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(push && room3),
    .in_byte(in_source_byte), .in_end(in_end_of_source),
    .tok_cnt(tok_cnt), .tok_data(tok_data)
  );

  cts_queue #(.TW(TW), .DEPTH(8)) u_queue (
    .clk(clk), .rst_n(rst_n), .wr_cnt(tok_cnt), .wr_data(tok_data),
    .rd_en(pop && !empty), .rd_data(rd_data), .empty(empty), .room3(room3)
  );

  // Split the queued token into its result fields.
  assign {out_token_kind, out_start_offset, out_start_line, out_start_column,
          out_token_length, out_offending_byte, out_last_of_run} = rd_data;

endmodule

[hw/rtl/cts_checker.sv]
// Port-level checker for the token scanner, bound to the top level.
// Depends on cts_pkg and assert_macros.svh.
`include "assert_macros.svh"
module cts_checker
  import cts_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       push,
  input logic       full,
  input logic       in_end_of_source,
  input logic       empty,
  input logic       pop,
  input logic [4:0] out_token_kind,
  input logic [7:0] out_offending_byte
);
  logic end_acc;
  logic good_tok;

  assign end_acc  = push && !full && in_end_of_source;
  assign good_tok = !empty && out_token_kind != TK_BAD;

  // An end-of-source transaction always yields at least an eof token.
  `CHK_NEXT(a_end_gives_tok, clk, rst_n, end_acc, !empty, "no token after end")
  // Kinds stay within the defined range.
  `CHK_IMPL(a_kind_range, clk, rst_n, !empty, out_token_kind <= TK_BAD, "token kind out of range")
  // Only invalid tokens carry an offending byte.
  `CHK_IMPL(a_bad_byte, clk, rst_n, good_tok, out_offending_byte == 8'h00, "stray offending byte")
endmodule

bind c_like_token_scanner_unit cts_checker u_cts_checker (.*);

[sim/tb_c_like_token_scanner_unit.sv]
// Testbench for the token scanner: drives source bytes and end marks, checks every token.
// Depends on cts_pkg and c_like_token_scanner_unit with its submodules.
module tb_c_like_token_scanner_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import cts_pkg::*;

  typedef struct packed {
    logic [4:0]  kind;
    logic [31:0] offset;
    logic [15:0] line;
    logic [15:0] column;
    logic [15:0] length;
    logic [7:0]  bad;
    logic        last;
  } token_t;

  typedef struct {
    logic [7:0] ch;
    logic       eos;
    logic       has_tok;
    token_t     tok;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic push = 1'b0;
  logic [7:0] in_source_byte = 8'h00;
  logic in_end_of_source = 1'b0;
  logic pop = 1'b0;
  logic full, empty;
  logic [4:0] out_token_kind;
  logic [31:0] out_start_offset;
  logic [15:0] out_start_line, out_start_column, out_token_length;
  logic [7:0] out_offending_byte;
  logic out_last_of_run;

  c_like_token_scanner_unit dut (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full),
    .in_source_byte(in_source_byte), .in_end_of_source(in_end_of_source),
    .empty(empty), .pop(pop), .out_token_kind(out_token_kind),
    .out_start_offset(out_start_offset), .out_start_line(out_start_line),
    .out_start_column(out_start_column), .out_token_length(out_token_length),
    .out_offending_byte(out_offending_byte), .out_last_of_run(out_last_of_run)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #50ms;
    $display("tb_c_like_token_scanner_unit: done, errors");
    $finish;
  end

  // Scanner state mirrored on the testbench side.
  scan_mode_t  mode;
  logic [31:0] cur_off, st_off;
  logic [15:0] cur_ln, cur_col, st_ln, st_col, st_len;
  logic [6:0]  kw_live;
  token_t      pending_tokens[$];
  token_t      burst[$];
  int          n_err = 0;
  int          send_idle = 0, recv_stall = 0;
  bit          hold_recv = 1'b0;

  function automatic bit digit_c(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction
  function automatic bit alpha_c(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction
  function automatic bit space_c(logic [7:0] c);
    return c == " " || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic string kw_word(int k);
    case (k)
      0: return "int";
      1: return "float";
      2: return "bool";
      3: return "return";
      4: return "if";
      5: return "else";
      default: return "while";
    endcase
  endfunction

  function automatic logic [15:0] sat16(logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  task automatic step_cursor(logic [7:0] c);
    cur_off = (cur_off == 32'hFFFF_FFFF) ? cur_off : cur_off + 32'd1;
    if (c == 8'h0A) begin
      cur_ln = sat16(cur_ln);
      cur_col = 16'd1;
    end else begin
      cur_col = sat16(cur_col);
    end
  endtask

  task automatic add_token(tok_kind_t k, logic [31:0] o, logic [15:0] l, logic [15:0] c,
                           logic [15:0] n, logic [7:0] b);
    token_t t;
    t = '{kind: k, offset: o, line: l, column: c, length: n, bad: b, last: 1'b0};
    burst.push_back(t);
  endtask

  task automatic lengthen(logic [7:0] c);
    st_len = sat16(st_len);
    step_cursor(c);
  endtask

  task automatic ident_grow(logic [7:0] c);
    string w;
    for (int k = 0; k < 7; k++) begin
      w = kw_word(k);
      if (st_len >= w.len() || w[st_len] != c) kw_live[k] = 1'b0;
    end
    lengthen(c);
  endtask

  function automatic tok_kind_t word_kind();
    string w;
    for (int k = 0; k < 7; k++) begin
      w = kw_word(k);
      if (kw_live[k] && st_len == w.len()) return tok_kind_t'(TK_KW_INT + k);
    end
    return TK_IDENT;
  endfunction

  task automatic flush_held();
    case (mode)
      M_IDENT: add_token(word_kind(), st_off, st_ln, st_col, st_len, 8'h00);
      M_INT:   add_token(TK_INTLIT, st_off, st_ln, st_col, st_len, 8'h00);
      M_INT_DOT: begin
        add_token(TK_INTLIT, st_off, st_ln, st_col, st_len, 8'h00);
        add_token(TK_BAD, cur_off, cur_ln, cur_col, 16'd1, ".");
        step_cursor(".");
      end
      M_FRAC:    add_token(TK_FLTLIT, st_off, st_ln, st_col, st_len, 8'h00);
      M_OP_EQ:   add_token(TK_ASSIGN, st_off, st_ln, st_col, st_len, 8'h00);
      M_OP_BANG: add_token(TK_BAD, st_off, st_ln, st_col, 16'd1, "!");
      M_OP_LT:   add_token(TK_LT, st_off, st_ln, st_col, st_len, 8'h00);
      M_OP_GT:   add_token(TK_GT, st_off, st_ln, st_col, st_len, 8'h00);
      default: ;
    endcase
    mode = M_IDLE;
  endtask

  task automatic begin_byte(logic [7:0] c);
    tok_kind_t k;
    if (space_c(c)) begin
      step_cursor(c);
      return;
    end
    st_off = cur_off;
    st_ln = cur_ln;
    st_col = cur_col;
    st_len = 16'd0;
    if (alpha_c(c) || c == "_") begin
      kw_live = 7'h7F;
      ident_grow(c);
      mode = M_IDENT;
    end else if (digit_c(c)) begin
      lengthen(c);
      mode = M_INT;
    end else if (c == "=" || c == "!" || c == "<" || c == ">") begin
      lengthen(c);
      mode = (c == "=") ? M_OP_EQ : (c == "!") ? M_OP_BANG : (c == "<") ? M_OP_LT : M_OP_GT;
    end else begin
      k = single_kind(c);
      add_token(k, cur_off, cur_ln, cur_col, 16'd1, (k == TK_BAD) ? c : 8'h00);
      step_cursor(c);
    end
  endtask

  // Predicts the tokens caused by one accepted transaction and queues them.
  task automatic predict_tokens(logic [7:0] c, logic eos);
    burst.delete();
    if (eos) begin
      flush_held();
      add_token(TK_EOF, cur_off, cur_ln, cur_col, 16'd0, 8'h00);
    end else begin
      case (mode)
        M_IDENT:
          if (alpha_c(c) || digit_c(c) || c == "_") ident_grow(c);
          else begin flush_held(); begin_byte(c); end
        M_INT:
          if (digit_c(c)) lengthen(c);
          else if (c == ".") mode = M_INT_DOT;
          else begin flush_held(); begin_byte(c); end
        M_INT_DOT:
          if (digit_c(c)) begin
            lengthen(".");
            lengthen(c);
            mode = M_FRAC;
          end else begin flush_held(); begin_byte(c); end
        M_FRAC:
          if (digit_c(c)) lengthen(c);
          else begin flush_held(); begin_byte(c); end
        M_OP_EQ, M_OP_BANG, M_OP_LT, M_OP_GT:
          if (c == "=") begin
            lengthen(c);
            add_token((mode == M_OP_EQ) ? TK_EQ : (mode == M_OP_BANG) ? TK_NE :
                      (mode == M_OP_LT) ? TK_LE : TK_GE, st_off, st_ln, st_col, st_len, 8'h00);
            mode = M_IDLE;
          end else begin flush_held(); begin_byte(c); end
        default: begin
          mode = M_IDLE;
          begin_byte(c);
        end
      endcase
    end
    if (burst.size() > 0) burst[burst.size()-1].last = 1'b1;
    foreach (burst[i]) pending_tokens.push_back(burst[i]);
  endtask

  // Sends one transaction, honouring the sender idling rate.
  task automatic send_byte(logic [7:0] c, logic eos);
    while ($urandom_range(99) < send_idle) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    in_source_byte <= c;
    in_end_of_source <= eos;
    @(posedge clk);
    while (full) @(posedge clk);
    predict_tokens(c, eos);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
  endtask

  task automatic drain();
    push <= 1'b0;
    while (pending_tokens.size() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Random source: mostly well-formed fragments, with noise bytes, newlines and end marks mixed in.
  task automatic random_fragment();
    string frags[16] = '{"int ", "float", "bool", "return ", "if(", "else{", "while ", "x_9",
                         "123", "4.56", "7.", "1.2.3", "!=", "<= >=", "== =", "!a"};
    int r;
    r = $urandom_range(9);
    if (r < 6) send_text(frags[$urandom_range(15)]);
    else if (r < 8) send_byte(8'($urandom_range(255)), 1'b0);
    else if (r < 9) send_byte(8'h0A, 1'b0);
    else send_byte(8'($urandom_range(255)), 1'b1);
  endtask

  // Result side: pops with random stalls and checks field by field.
  always @(posedge clk) begin
    token_t exp_tok;
    if (rst_n) begin
      if (pop && !empty) begin
        if (pending_tokens.size() == 0) begin
          $error("token with no expectation: kind %0d", out_token_kind);
          n_err++;
        end else begin
          exp_tok = pending_tokens.pop_front();
          if (out_token_kind !== exp_tok.kind) begin
            $error("token_kind exp %0d got %0d", exp_tok.kind, out_token_kind); n_err++;
          end
          if (out_start_offset !== exp_tok.offset) begin
            $error("start_offset exp %0d got %0d", exp_tok.offset, out_start_offset); n_err++;
          end
          if (out_start_line !== exp_tok.line) begin
            $error("start_line exp %0d got %0d", exp_tok.line, out_start_line); n_err++;
          end
          if (out_start_column !== exp_tok.column) begin
            $error("start_column exp %0d got %0d", exp_tok.column, out_start_column); n_err++;
          end
          if (out_token_length !== exp_tok.length) begin
            $error("token_length exp %0d got %0d", exp_tok.length, out_token_length); n_err++;
          end
          if (out_offending_byte !== exp_tok.bad) begin
            $error("offending_byte exp %0d got %0d", exp_tok.bad, out_offending_byte); n_err++;
          end
          if (out_last_of_run !== exp_tok.last) begin
            $error("last_of_run exp %0d got %0d", exp_tok.last, out_last_of_run); n_err++;
          end
        end
      end
      pop <= !hold_recv && ($urandom_range(99) >= recv_stall);
    end
  end

  // Directed table: expected token filled in only where obvious from reset state.
  stim_row_t rows[$];
  initial begin
    token_t t0;
    mode = M_IDLE;
    cur_off = 0; cur_ln = 1; cur_col = 1;
    st_off = 0; st_ln = 1; st_col = 1; st_len = 0; kw_live = 7'h7F;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    t0 = '{kind: TK_EOF, offset: 0, line: 1, column: 1, length: 0, bad: 0, last: 1'b1};
    rows.push_back('{ch: 8'hFF, eos: 1'b1, has_tok: 1'b1, tok: t0});
    t0 = '{kind: TK_BAD, offset: 0, line: 1, column: 1, length: 1, bad: 8'hFF, last: 1'b1};
    rows.push_back('{ch: 8'hFF, eos: 1'b0, has_tok: 1'b1, tok: t0});
    foreach (rows[i]) begin
      send_byte(rows[i].ch, rows[i].eos);
      if (rows[i].has_tok && pending_tokens[pending_tokens.size()-1] !== rows[i].tok) begin
        $error("directed row %0d: predictor disagrees with table", i);
        n_err++;
      end
    end
    send_text("int float bool return if else while whilex _a9\n");
    send_text("1.2.3 3.x=== !x<=>= <>!=+-*/(){};,@\t\v\f\r");
    send_byte(8'h00, 1'b0);
    send_text("9.");
    send_byte(8'h00, 1'b1);
    send_text("<");
    send_byte(8'h00, 1'b1);
    send_text("!");
    send_byte(8'h80, 1'b1);
    drain();

    // Idling phases: none, sender, receiver, both.
    for (int ph = 0; ph < 4; ph++) begin
      send_idle = (ph == 1 || ph == 3) ? ((ph == 1) ? 59 : 26) : 0;
      recv_stall = (ph == 2 || ph == 3) ? ((ph == 2) ? 59 : 26) : 0;
      for (int i = 0; i < 3; i++) random_fragment();
      drain();
    end

    // Long receiver hold-off so the token queue fills and stalls the input.
    send_idle = 0;
    recv_stall = 0;
    fork
      begin
        hold_recv = 1'b1;
        repeat (200) @(posedge clk);
        hold_recv = 1'b0;
      end
      for (int i = 0; i < 5; i++) send_text("a+ ");
    join
    send_byte(8'h00, 1'b1);
    drain();
    repeat (10) @(posedge clk);

    if (n_err == 0 && pending_tokens.size() == 0) begin
      $display("tb_c_like_token_scanner_unit: done, clean");
    end else begin
      $display("tb_c_like_token_scanner_unit: done, errors");
    end
    $finish;
  end
endmodule
